// ----- rtl/cga_crtc_register_interface_assert.svh -----
// assertion macros shared by the cga crtc checker
`ifndef CGA_CRTC_REGISTER_INTERFACE_ASSERT_SVH
`define CGA_CRTC_REGISTER_INTERFACE_ASSERT_SVH

// property that must hold at every edge outside reset
`define CGACRTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CGACRTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cgacrtc_pkg.sv -----
// shared types, codes and helpers of the cga crtc port block
`default_nettype none

package cgacrtc_pkg;

   // request op codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FRAME = 2'd2;

   // i/o ports
   localparam logic [15:0] PORT_INDEX  = 16'h03D4;
   localparam logic [15:0] PORT_DATA   = 16'h03D5;
   localparam logic [15:0] PORT_MODE   = 16'h03D8;
   localparam logic [15:0] PORT_STATUS = 16'h03DA;

   // crtc register indexes
   localparam logic [3:0] REG_HTOTAL       = 4'd0;
   localparam logic [3:0] REG_HSYNC_POS    = 4'd2;
   localparam logic [3:0] REG_HSYNC_WIDTH  = 4'd3;
   localparam logic [3:0] REG_VDISPLAYED   = 4'd6;
   localparam logic [3:0] REG_VSYNC_POS    = 4'd7;
   localparam logic [3:0] REG_INTERLACE    = 4'd8;
   localparam logic [3:0] REG_MAX_SCAN     = 4'd9;
   localparam logic [3:0] REG_CURSOR_START = 4'd10;
   localparam logic [3:0] REG_CURSOR_END   = 4'd11;
   localparam logic [3:0] REG_START_HI     = 4'd12;
   localparam logic [3:0] REG_START_LO     = 4'd13;
   localparam logic [3:0] REG_CURSOR_HI    = 4'd14;
   localparam logic [3:0] REG_CURSOR_LO    = 4'd15;

   localparam int CRTC_DEPTH      = 16;
   localparam int CURSOR_OFF_BIT  = 5;
   localparam int MODE_RESET_BIT  = 7;
   localparam int MODE_UPDATE_BIT = 6;

   localparam logic [7:0] STATUS_BASE  = 8'hF0;
   localparam logic [7:0] DEFAULT_ROWS = 8'd25;
   localparam logic [4:0] TALL_SCAN    = 5'd9;
   localparam logic [4:0] SHORT_SCAN   = 5'd7;

   typedef struct packed {
      logic        valid;
      logic [1:0]  op;
      logic [15:0] port;
      logic [7:0]  write_data;
   } req_cmd_type;

   typedef struct packed {
      logic [7:0]  htotal;
      logic [7:0]  hsync_pos;
      logic [7:0]  hsync_width;
      logic [7:0]  vdisplayed;
      logic [7:0]  vsync_pos;
      logic [7:0]  interlace;
      logic [4:0]  max_scan;
      logic [15:0] start_address;
      logic [15:0] cursor_loc;
      logic [6:0]  mode_bits;
      logic        reset_pending;
      logic        cursor_shown;
   } crtc_view_type;

   // scan lines per character row
   function automatic logic [5:0] row_scan_count(input logic [4:0] max_scan,
                                                 input logic [7:0] rows_reg,
                                                 input logic       high_res);
      logic [4:0] ms;
      logic       rows25;
      ms     = max_scan;
      rows25 = (rows_reg == 8'd0) || (rows_reg == DEFAULT_ROWS);
      if (high_res && ms == SHORT_SCAN) begin
         ms = TALL_SCAN;
      end
      if (ms == 5'd0 && rows25) begin
         ms = high_res ? TALL_SCAN : SHORT_SCAN;
      end
      return {1'b0, ms} + 6'd1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cgacrtc_div.sv -----
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module cgacrtc_div import cgacrtc_pkg::*; #(
   parameter int DW = 15
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [7:0]    divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);

   localparam int CNTW = $clog2(DW + 1);

   logic [CNTW-1:0] count_ff, count_in;
   logic            done_ff, done_in;
   logic [DW-1:0]   quot_ff, quot_in;
   logic [7:0]      rem_ff, rem_in;
   logic [7:0]      divisor_ff, divisor_in;
   logic [8:0]      rem_shift;
   logic [8:0]      rem_diff;
   logic            fits;

   assign rem_shift = {rem_ff, quot_ff[DW-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      if (start) begin
         count_in   = CNTW'(DW);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quot_in  = {quot_ff[DW-2:0], fits};
         rem_in   = fits ? rem_diff[7:0] : rem_shift[7:0];
         done_in  = (count_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- rtl/cgacrtc_regs.sv -----
// crtc index and data registers, mode register and port decode
`default_nettype none

module cgacrtc_regs import cgacrtc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_cmd_type cmd,
   output logic [7:0]       read_data,
   output logic             update_request,
   output crtc_view_type    view
);

   logic [7:0] index_ff, index_in;
   logic [7:0] crtc_ff [CRTC_DEPTH];
   logic [7:0] crtc_in [CRTC_DEPTH];
   logic       cursor_ff, cursor_in;
   logic [6:0] mode_ff, mode_in;
   logic       rflag_ff, rflag_in;
   logic       is_read, is_write;

   assign is_read  = cmd.valid && (cmd.op == OP_READ);
   assign is_write = cmd.valid && (cmd.op == OP_WRITE);

   always_comb begin
      index_in  = index_ff;
      crtc_in   = crtc_ff;
      cursor_in = cursor_ff;
      mode_in   = mode_ff;
      rflag_in  = rflag_ff;
      if (is_write && cmd.port == PORT_INDEX) begin
         index_in = cmd.write_data;
      end else if (is_write && cmd.port == PORT_DATA && index_ff[7:4] == 4'd0) begin
         unique case (index_ff[3:0])
            REG_MAX_SCAN, REG_CURSOR_END: begin
               crtc_in[index_ff[3:0]] = {3'd0, cmd.write_data[4:0]};
            end
            REG_CURSOR_START: begin
               crtc_in[index_ff[3:0]] = {3'd0, cmd.write_data[4:0]};
               cursor_in = !cmd.write_data[CURSOR_OFF_BIT];
            end
            default: begin
               crtc_in[index_ff[3:0]] = cmd.write_data;
            end
         endcase
      end else if (is_write && cmd.port == PORT_MODE) begin
         if (cmd.write_data[MODE_RESET_BIT]) begin
            rflag_in = 1'b1;
         end
         mode_in = cmd.write_data[6:0];
      end else if (cmd.valid && cmd.op == OP_FRAME) begin
         rflag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         crtc_ff   <= '{default: '0};
         cursor_ff <= 1'b0;
         mode_ff   <= '0;
         rflag_ff  <= 1'b0;
      end else begin
         index_ff  <= index_in;
         crtc_ff   <= crtc_in;
         cursor_ff <= cursor_in;
         mode_ff   <= mode_in;
         rflag_ff  <= rflag_in;
      end
   end

   // only the cursor location reads back
   always_comb begin
      read_data = '0;
      if (is_read && cmd.port == PORT_DATA) begin
         if (index_ff == {4'd0, REG_CURSOR_HI}) begin
            read_data = crtc_ff[REG_CURSOR_HI];
         end else if (index_ff == {4'd0, REG_CURSOR_LO}) begin
            read_data = crtc_ff[REG_CURSOR_LO];
         end
      end
   end

   assign update_request = is_write && (cmd.port == PORT_MODE)
                           && cmd.write_data[MODE_UPDATE_BIT];

   assign view.htotal        = crtc_ff[REG_HTOTAL];
   assign view.hsync_pos     = crtc_ff[REG_HSYNC_POS];
   assign view.hsync_width   = crtc_ff[REG_HSYNC_WIDTH];
   assign view.vdisplayed    = crtc_ff[REG_VDISPLAYED];
   assign view.vsync_pos     = crtc_ff[REG_VSYNC_POS];
   assign view.interlace     = crtc_ff[REG_INTERLACE];
   assign view.max_scan      = crtc_ff[REG_MAX_SCAN][4:0];
   assign view.start_address = {crtc_ff[REG_START_HI], crtc_ff[REG_START_LO]};
   assign view.cursor_loc    = {crtc_ff[REG_CURSOR_HI], crtc_ff[REG_CURSOR_LO]};
   assign view.mode_bits     = mode_ff;
   assign view.reset_pending = rflag_ff;
   assign view.cursor_shown  = cursor_ff;

endmodule

`default_nettype wire

// ----- rtl/cga_crtc_register_interface.sv -----
// top level of the cga crtc port block: sequencer, status logic and result register
//
// One port access enters per word on the req channel and gives one word on the
// rsp channel. Index, data, mode and frame-start words and all reads other than
// the status port have their rsp word registered as they are taken, so the next
// word can be taken on the following edge unless rsp_stall holds the rsp word.
// A read of the status port (0x3DA) runs the horizontal sync start and end
// through one shared bit-serial divider of DW = 8 + clog2(HSYNC_SCALE+1) bits,
// one quotient bit per cycle; req_stall is high until status is registered.
// The cursor, start address, mode, reset flag and cursor visibility fields
// show the register state left by the word being returned.
`default_nettype none

module cga_crtc_register_interface import cgacrtc_pkg::*; #(
   parameter int VSYNC_LINES = 16,
   parameter int HSYNC_SCALE = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_port,
   input  wire logic [7:0]  req_write_data,
   input  wire logic [9:0]  req_scanline,
   input  wire logic [15:0] req_line_time_us,
   input  wire logic [9:0]  req_display_start,
   input  wire logic [9:0]  req_display_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic [15:0]      rsp_cursor_loc,
   output logic [15:0]      rsp_start_address,
   output logic [6:0]       rsp_mode_bits,
   output logic             rsp_reset_pending,
   output logic             rsp_update_request,
   output logic             rsp_cursor_shown
);

   localparam int DW  = 8 + $clog2(HSYNC_SCALE + 1);
   localparam int HW  = DW + 1;
   localparam int CW  = (HW > 16) ? HW : 16;
   localparam int VSW = $clog2(1023 + 255 * 32 + 2 + VSYNC_LINES);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIV_HS = 2'd1;
   localparam logic [1:0] ST_DIV_HE = 2'd2;
   localparam logic [1:0] ST_STATUS = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic           rsp_upd_ff, rsp_upd_in;
   logic [9:0]     line_ff, ds_ff, de_ff;
   logic [15:0]    ltime_ff;
   logic [VSW-1:0] vstart_ff;
   logic [DW-1:0]  hs_ff, hs_in;
   logic [HW-1:0]  he_ff, he_in;

   req_cmd_type    cmd;
   crtc_view_type  view;
   logic [7:0]     regs_read;
   logic           regs_update;

   logic           out_free, accept, is_status;
   logic           div_start, div_done;
   logic [DW-1:0]  div_dividend, div_quot;
   logic [7:0]     htot;
   logic [5:0]     height;
   logic [13:0]    vsync_ofs;
   logic [VSW-1:0] vstart_calc, vend, line_ext;
   logic [CW-1:0]  ltime_ext;
   logic           vblank, vsync, hblank;
   logic [7:0]     status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign is_status = (req_op == OP_READ) && (req_port == PORT_STATUS);

   assign cmd.valid      = accept;
   assign cmd.op         = req_op;
   assign cmd.port       = req_port;
   assign cmd.write_data = req_write_data;

   cgacrtc_regs u_regs (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .read_data      (regs_read),
      .update_request (regs_update),
      .view           (view)
   );

   // horizontal total of zero divides as one
   assign htot = (view.htotal == 8'd0) ? 8'd1 : view.htotal;

   assign div_start    = (accept && is_status) || (state_ff == ST_DIV_HS && div_done);
   assign div_dividend = (state_ff == ST_IDLE)
                         ? DW'(view.hsync_pos) * DW'(HSYNC_SCALE)
                         : DW'(view.hsync_width) * DW'(HSYNC_SCALE);

   cgacrtc_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (htot),
      .done     (div_done),
      .quotient (div_quot)
   );

   // vertical sync start, registered when the status read is taken
   assign height      = row_scan_count(view.max_scan, view.vdisplayed, view.mode_bits[0]);
   assign vsync_ofs   = 14'(view.vsync_pos * height);
   assign vstart_calc = VSW'(req_display_start) + VSW'(vsync_ofs)
                        + VSW'(view.interlace != 8'd0);

   assign line_ext  = VSW'(line_ff);
   assign vend      = vstart_ff + VSW'(VSYNC_LINES);
   assign ltime_ext = CW'(ltime_ff);
   assign vblank    = (line_ff < ds_ff) || (line_ff >= de_ff);
   assign vsync     = (line_ext >= vstart_ff) && (line_ext < vend);
   assign hblank    = (ltime_ext >= CW'(hs_ff)) && (ltime_ext <= CW'(he_ff));
   assign status    = STATUS_BASE | {4'd0, vsync, 2'd0, vblank | hblank};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_upd_in   = rsp_upd_ff;
      hs_in        = hs_ff;
      he_in        = he_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_status) begin
               state_in = ST_DIV_HS;
            end else if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = regs_read;
               rsp_upd_in   = regs_update;
            end
         end
         ST_DIV_HS: begin
            if (div_done) begin
               hs_in    = div_quot;
               state_in = ST_DIV_HE;
            end
         end
         ST_DIV_HE: begin
            if (div_done) begin
               he_in    = HW'(hs_ff) + HW'(div_quot);
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = status;
            rsp_upd_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_upd_ff  <= rsp_upd_in;
      hs_ff       <= hs_in;
      he_ff       <= he_in;
      if (accept && is_status) begin
         line_ff   <= req_scanline;
         ltime_ff  <= req_line_time_us;
         ds_ff     <= req_display_start;
         de_ff     <= req_display_end;
         vstart_ff <= vstart_calc;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_update_request = rsp_upd_ff;
   assign rsp_cursor_loc     = view.cursor_loc;
   assign rsp_start_address  = view.start_address;
   assign rsp_mode_bits      = view.mode_bits;
   assign rsp_reset_pending  = view.reset_pending;
   assign rsp_cursor_shown   = view.cursor_shown;

endmodule

`default_nettype wire

// ----- rtl/cgacrtc_checker.sv -----
// port-level checks of the cga crtc port block and their bind
`default_nettype none

`include "cga_crtc_register_interface_assert.svh"

module cgacrtc_checker import cgacrtc_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_op,
   input wire logic [15:0] req_port,
   input wire logic [7:0]  req_write_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_read_data,
   input wire logic        rsp_reset_pending,
   input wire logic        rsp_update_request
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // a pending word blocks new requests
   `CGACRTC_ASSERT(a_block_when_full, !(rsp_valid && rsp_stall) || req_stall, "req taken while rsp held")

   // update pulse only on a mode write, which reads nothing
   `CGACRTC_ASSERT(a_update_no_data, !(rsp_valid && rsp_update_request) || rsp_read_data == 8'd0, "update with read data")

   // mode write with reset bit shows the flag on the next word
   `CGACRTC_ASSERT_NEXT(a_mode_reset, req_take && req_op == OP_WRITE && req_port == PORT_MODE && req_write_data[7], rsp_valid && rsp_reset_pending, "reset flag not raised")

   // frame start clears the flag in the cycle after it is taken
   `CGACRTC_ASSERT_NEXT(a_frame_clear, req_take && req_op == OP_FRAME, rsp_valid && !rsp_reset_pending && !rsp_update_request, "frame start result wrong")

   `CGACRTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data), "stalled rsp word changed")

endmodule

bind cga_crtc_register_interface cgacrtc_checker u_cgacrtc_checker (.*);

`default_nettype wire
